// ----- rtl/core/swma_pkg.sv -----
// Package for the selectable-window moving average: window codes, lengths and field widths.
// No dependencies; used by swma_out_if, the core and the bench.
`timescale 1ns / 1ps
`default_nettype none

package swma_pkg;

    localparam int CODE_BITS = 8;
    localparam int AVG_BITS  = 12;
    localparam int LEN_BITS  = 12;

    typedef logic [CODE_BITS-1:0] t_code;
    typedef logic [AVG_BITS-1:0]  t_avg;
    typedef logic [LEN_BITS-1:0]  t_len;

    localparam t_code CODE_W200  = 8'd0;
    localparam t_code CODE_W1000 = 8'd1;
    localparam t_code CODE_W2000 = 8'd2;
    localparam t_code CODE_W4000 = 8'd3;

    localparam t_len WIN_LEN0 = 12'd200;
    localparam t_len WIN_LEN1 = 12'd1000;
    localparam t_len WIN_LEN2 = 12'd2000;
    localparam t_len WIN_LEN3 = 12'd4000;

    function automatic t_len code_to_len(input t_code code);
        t_len len;
        unique case (code)
            CODE_W200:  len = WIN_LEN0;
            CODE_W1000: len = WIN_LEN1;
            CODE_W2000: len = WIN_LEN2;
            CODE_W4000: len = WIN_LEN3;
            default:    len = LEN_BITS'(code);
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/swma_in_if.sv -----
// Sample channel: valid/ready handshake carrying one converter sample per beat.
// Depends on nothing; width set by parameter.
`timescale 1ns / 1ps
`default_nettype none

interface swma_in_if #(
    parameter int W = 12
);
    logic         valid;
    logic         ready;
    logic [W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/swma_out_if.sv -----
// Average channel: valid/ready handshake carrying one average per beat.
// Depends on swma_pkg for the average width.
`timescale 1ns / 1ps
`default_nettype none

interface swma_out_if;
    logic          valid;
    logic          ready;
    swma_pkg::t_avg average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/selectable_window_moving_average_core.sv -----
// Boxcar moving average over a selectable window with refill after a window change.
// Depends on swma_pkg, swma_in_if, swma_out_if and swma_ram.
//
//   channel        dir  signals                         beat
//   i_sample_ch    in   valid, ready, sample            one sample
//   o_average_ch   out  valid, ready, average           one average
//   i_cfg_*        in   i_cfg_we, i_cfg_wdata (code)    write when i_cfg_we
//
// Normal sample: S_UPD updates store and running sum, then the bit-serial restoring
// divider in S_DIV gives one quotient bit per cycle. Refill sample: an S_FILL walk
// first rewrites the window, one store entry per cycle. Reset leaves the store unwritten; a
// fill count makes unwritten entries read as zero, so no clearing pass. The output
// register holds a finished average; a stalled sink holds the divider in its last state.
`timescale 1ns / 1ps
`default_nettype none

module selectable_window_moving_average_core #(
    parameter int DEPTH       = 4096,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    swma_in_if.sink                       i_sample_ch,
    swma_out_if.source                    o_average_ch,
    input  wire logic                     i_cfg_we,
    input  wire swma_pkg::t_code          i_cfg_wdata
);

    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int LW        = ADDR_BITS + 1;
    localparam int SUM_BITS  = SAMPLE_BITS + ADDR_BITS;
    localparam int DCNT_BITS = $clog2(SUM_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_FILL,
        S_DIV,
        S_DONE
    } t_state;

    t_state                 r_state;
    swma_pkg::t_code        r_wcode;
    logic                   r_refill;
    logic [ADDR_BITS-1:0]   r_idx;
    logic [LW-1:0]          r_fill;
    logic [SUM_BITS-1:0]    r_sum;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SAMPLE_BITS-1:0] r_v;
    logic [ADDR_BITS-1:0]   r_cnt;
    logic [SUM_BITS-1:0]    r_quo;
    logic [LW-1:0]          r_rem;
    logic [DCNT_BITS-1:0]   r_dcnt;
    logic                   r_out_valid;
    swma_pkg::t_avg         r_avg;

    swma_pkg::t_len         base_len;
    logic [LW-1:0]          len;
    logic [SAMPLE_BITS-1:0] rdata;
    logic [SAMPLE_BITS-1:0] old_val;
    logic [LW-1:0]          idx_inc;
    logic [LW:0]            rem_sh;
    logic                   q_bit;
    logic [LW-1:0]          n_rem;
    logic [SUM_BITS-1:0]    n_sum;
    logic                   accept;
    logic                   load_out;
    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;

    always_comb begin
        base_len = swma_pkg::code_to_len(r_wcode);
        if (32'(base_len) > 32'(DEPTH)) begin
            len = LW'(DEPTH);
        end else begin
            len = LW'(base_len);
        end
    end

    assign accept   = i_sample_ch.valid && (r_state == S_IDLE);
    assign old_val  = ({1'b0, r_idx} < r_fill) ? rdata : '0;
    assign idx_inc  = {1'b0, r_idx} + LW'(1);
    assign n_sum    = r_sum - SUM_BITS'(old_val) + SUM_BITS'(r_sample);
    assign rem_sh   = {r_rem, r_quo[SUM_BITS-1]};
    assign q_bit    = rem_sh >= {1'b0, len};
    assign n_rem    = q_bit ? LW'(rem_sh - {1'b0, len}) : LW'(rem_sh);
    assign load_out = (r_state == S_DONE) && (!r_out_valid || o_average_ch.ready);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = r_sample;
        if (r_state == S_UPD && !r_refill) begin
            ram_we = 1'b1;
        end else if (r_state == S_FILL) begin
            ram_we    = 1'b1;
            ram_waddr = r_cnt;
            ram_wdata = r_v;
        end
    end

    swma_ram #(
        .W (SAMPLE_BITS),
        .D (DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wcode     <= swma_pkg::CODE_W200;
            r_refill    <= 1'b1;
            r_idx       <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_sample <= i_sample_ch.sample;
                        r_state  <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_rem  <= '0;
                    r_dcnt <= '0;
                    if (r_refill) begin
                        r_refill <= 1'b0;
                        r_v      <= old_val;
                        r_sum    <= '0;
                        r_cnt    <= '0;
                        r_state  <= S_FILL;
                    end else begin
                        r_sum   <= n_sum;
                        r_quo   <= n_sum;
                        r_idx   <= (idx_inc >= len) ? '0 : r_idx + ADDR_BITS'(1);
                        r_fill  <= (idx_inc > r_fill) ? idx_inc : r_fill;
                        r_state <= S_DIV;
                    end
                end
                S_FILL: begin
                    r_sum <= r_sum + SUM_BITS'(r_v);
                    r_cnt <= r_cnt + ADDR_BITS'(1);
                    if ({1'b0, r_cnt} == len - LW'(1)) begin
                        r_quo   <= r_sum + SUM_BITS'(r_v);
                        r_idx   <= '0;
                        r_fill  <= (len > r_fill) ? len : r_fill;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= n_rem;
                    r_quo  <= {r_quo[SUM_BITS-2:0], q_bit};
                    r_dcnt <= r_dcnt + DCNT_BITS'(1);
                    if (r_dcnt == DCNT_BITS'(SUM_BITS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (load_out) begin
                r_out_valid <= 1'b1;
                r_avg       <= r_quo[swma_pkg::AVG_BITS-1:0];
            end else if (o_average_ch.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                r_wcode  <= i_cfg_wdata;
                r_refill <= 1'b1;
            end
        end
    end

    assign i_sample_ch.ready    = (r_state == S_IDLE);
    assign o_average_ch.valid   = r_out_valid;
    assign o_average_ch.average = r_avg;

    a_fill_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FILL |-> {1'b0, r_cnt} < len)
        else $error("refill walk beyond window");

    a_idx_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_refill) |-> {1'b0, r_idx} < len)
        else $error("write index outside window");

    a_idx_in_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_idx} <= r_fill)
        else $error("write index beyond filled prefix");

    a_rem_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < len)
        else $error("divider remainder out of range");

endmodule

`default_nettype wire

// ----- rtl/core/swma_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module swma_ram #(
    parameter int W = 12,
    parameter int D = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- tb/sv/selectable_window_moving_average_core_test.sv -----
// Self-checking bench for the selectable-window moving average core: a directed table, then
// random window phases, with bursty samples and a stalling sink checked against a boxcar predictor.
// Depends on swma_pkg, swma_in_if, swma_out_if and selectable_window_moving_average_core.
`timescale 1ns / 1ps
`default_nettype none

module selectable_window_moving_average_core_test;

    localparam int DEPTH        = 4096;
    localparam int SAMPLE_BITS  = 12;
    localparam int RANDOM_ITEMS = 1600;
    localparam int LONG_STALL   = 300;
    localparam int STALL_ITEMS  = 8;

    typedef logic [SAMPLE_BITS-1:0] t_sample;

    typedef enum logic {ROW_SAMPLE, ROW_WINDOW} t_row_kind;

    typedef struct packed {
        t_row_kind      kind;
        t_sample        value;
        logic           typed;
        swma_pkg::t_avg avg;
    } t_row;

    typedef struct {
        swma_pkg::t_avg avg;
        int             seq;
    } t_pending;

    localparam int DIR_ROWS = 32;

    localparam t_row DIR_TABLE [DIR_ROWS] = '{
        '{ROW_SAMPLE, 12'd4095, 1'b1, 12'd0},
        '{ROW_SAMPLE, 12'd4095, 1'b1, 12'd20},
        '{ROW_SAMPLE, 12'd0,    1'b0, 12'd0},
        '{ROW_WINDOW, 12'd4,    1'b0, 12'd0},
        '{ROW_SAMPLE, 12'd123,  1'b1, 12'd0},
        '{ROW_SAMPLE, 12'd4095, 1'b1, 12'd1023},
        '{ROW_SAMPLE, 12'd4095, 1'b1, 12'd2047},
        '{ROW_SAMPLE, 12'd4095, 1'b1, 12'd3071},
        '{ROW_SAMPLE, 12'd4095, 1'b1, 12'd4095},
        '{ROW_SAMPLE, 12'd0,    1'b0, 12'd0},
        '{ROW_WINDOW, 12'd255,  1'b0, 12'd0},
        '{ROW_SAMPLE, 12'd0,    1'b0, 12'd0},
        '{ROW_SAMPLE, 12'd1,    1'b0, 12'd0},
        '{ROW_SAMPLE, 12'd2048, 1'b0, 12'd0},
        '{ROW_SAMPLE, 12'd2730, 1'b0, 12'd0},
        '{ROW_SAMPLE, 12'd1365, 1'b0, 12'd0},
        '{ROW_SAMPLE, 12'd4095, 1'b0, 12'd0},
        '{ROW_WINDOW, 12'd4,    1'b0, 12'd0},
        '{ROW_SAMPLE, 12'd77,   1'b0, 12'd0},
        '{ROW_SAMPLE, 12'd1000, 1'b0, 12'd0},
        '{ROW_WINDOW, 12'd4,    1'b0, 12'd0},
        '{ROW_SAMPLE, 12'd3000, 1'b0, 12'd0},
        '{ROW_WINDOW, t_sample'(swma_pkg::CODE_W4000), 1'b0, 12'd0},
        '{ROW_SAMPLE, 12'd0,    1'b0, 12'd0},
        '{ROW_SAMPLE, 12'd4095, 1'b0, 12'd0},
        '{ROW_WINDOW, t_sample'(swma_pkg::CODE_W1000), 1'b0, 12'd0},
        '{ROW_SAMPLE, 12'd2222, 1'b0, 12'd0},
        '{ROW_WINDOW, t_sample'(swma_pkg::CODE_W2000), 1'b0, 12'd0},
        '{ROW_SAMPLE, 12'd5,    1'b0, 12'd0},
        '{ROW_WINDOW, t_sample'(swma_pkg::CODE_W200),  1'b0, 12'd0},
        '{ROW_SAMPLE, 12'd3333, 1'b0, 12'd0},
        '{ROW_SAMPLE, 12'd4095, 1'b0, 12'd0}
    };

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    swma_pkg::t_code i_cfg_wdata;

    swma_in_if #(.W(SAMPLE_BITS)) sample_ch ();
    swma_out_if                   average_ch ();

    selectable_window_moving_average_core #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample_ch  (sample_ch),
        .o_average_ch (average_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    t_sample         ring [DEPTH];
    int              ring_idx;
    longint          ring_sum;
    bit              refill_due;
    swma_pkg::t_code win_code;

    t_pending avg_expect [$];
    int       fail_count;
    int       sent_count;
    int       burst_left;
    bit       stall_req;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int window_len(input swma_pkg::t_code c);
        int len;
        unique case (c)
            swma_pkg::CODE_W200:  len = int'(swma_pkg::WIN_LEN0);
            swma_pkg::CODE_W1000: len = int'(swma_pkg::WIN_LEN1);
            swma_pkg::CODE_W2000: len = int'(swma_pkg::WIN_LEN2);
            swma_pkg::CODE_W4000: len = int'(swma_pkg::WIN_LEN3);
            default:              len = int'(c);
        endcase
        if (len > DEPTH) len = DEPTH;
        if (len == 0) len = 1;
        return len;
    endfunction

    function automatic swma_pkg::t_avg boxcar_step(input t_sample s);
        int      len;
        int      idx;
        t_sample v;
        len = window_len(win_code);
        idx = (ring_idx >= DEPTH) ? 0 : ring_idx;
        if (refill_due) begin
            v = ring[idx];
            refill_due = 1'b0;
            for (int i = 0; i < len; i++) ring[i] = v;
            ring_sum = longint'(v) * len;
            ring_idx = 0;
        end else begin
            ring_sum = ring_sum - ring[idx] + s;
            ring[idx] = s;
            idx++;
            ring_idx = (idx >= len) ? 0 : idx;
        end
        return swma_pkg::t_avg'(ring_sum / len);
    endfunction

    task automatic report_mismatch(input string what, input int seq, input swma_pkg::t_avg got,
                                   input swma_pkg::t_avg want);
        fail_count++;
        $display("%0t ns: %s (beat %0d): got %0d, want %0d", $time, what, seq, got, want);
    endtask

    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (avg_expect.size() != 0);
    endtask

    task automatic write_window(input swma_pkg::t_code code);
        wait_idle();
        repeat ($urandom_range(2, 6)) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= code;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        win_code   = code;
        refill_due = 1'b1;
    endtask

    task automatic send_sample(input t_sample s, input logic typed,
                               input swma_pkg::t_avg typed_avg);
        int       gap;
        t_pending beat;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        do @(posedge i_clk); while (!sample_ch.ready);
        beat.avg = boxcar_step(s);
        if (typed) beat.avg = typed_avg;
        beat.seq = sent_count;
        sent_count++;
        avg_expect.push_back(beat);
    endtask

    always @(posedge i_clk) begin
        t_pending head;
        if (i_rst_n && average_ch.valid && average_ch.ready) begin
            if (avg_expect.size() == 0) begin
                report_mismatch("average beat with nothing pending", -1, average_ch.average, '0);
            end else begin
                head = avg_expect.pop_front();
                if (average_ch.average !== head.avg)
                    report_mismatch("average mismatch", head.seq, average_ch.average, head.avg);
            end
        end
    end

    initial begin
        int mode;
        int mode_left;
        int tick;
        int held;
        average_ch.ready = 1'b0;
        mode_left = 0;
        mode = 0;
        tick = 0;
        held = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (stall_req) begin
                average_ch.ready <= 1'b0;
                held++;
                if (held >= LONG_STALL) stall_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                unique case (mode)
                    0:       average_ch.ready <= 1'b1;
                    1:       average_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: average_ch.ready <= ((tick % 4) == 0);
                endcase
            end
        end
    end

    initial begin
        int              total;
        int              n;
        int              pick;
        swma_pkg::t_code code;
        t_sample         s;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        fail_count = 0;
        sent_count = 0;
        burst_left = 0;
        stall_req  = 1'b0;
        for (int i = 0; i < DEPTH; i++) ring[i] = '0;
        ring_idx   = 0;
        ring_sum   = 0;
        refill_due = 1'b1;
        win_code   = swma_pkg::CODE_W200;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_TABLE[r]) begin
            if (DIR_TABLE[r].kind == ROW_WINDOW)
                write_window(swma_pkg::t_code'(DIR_TABLE[r].value));
            else
                send_sample(DIR_TABLE[r].value, DIR_TABLE[r].typed, DIR_TABLE[r].avg);
        end

        // hold the sink off while the source keeps pushing
        wait_idle();
        stall_req = 1'b1;
        total = 0;
        for (int i = 0; i < STALL_ITEMS; i++) begin
            send_sample(t_sample'($urandom_range(0, 4095)), 1'b0, '0);
            total++;
        end
        while (total < RANDOM_ITEMS) begin
            wait_idle();
            if ($urandom_range(0, 4) != 0) begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    code = swma_pkg::t_code'($urandom_range(0, 3));
                else if (pick <= 3)
                    code = swma_pkg::t_code'($urandom_range(17, 255));
                else
                    code = swma_pkg::t_code'($urandom_range(4, 16));
                write_window(code);
            end
            n = $urandom_range(20, 120);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 7) == 0)
                    s = $urandom_range(0, 1) ? '1 : '0;
                else
                    s = t_sample'($urandom_range(0, 4095));
                send_sample(s, 1'b0, '0);
                total++;
            end
        end

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/swma_pkg.sv
rtl/core/swma_in_if.sv
rtl/core/swma_out_if.sv
rtl/core/swma_ram.sv
rtl/core/selectable_window_moving_average_core.sv
tb/sv/selectable_window_moving_average_core_test.sv
